// File: design/sh24_pkg.sv
package sh24_pkg;

  // Initialisation constants of the four lanes
  localparam logic [63:0] SipC0 = 64'h736f6d6570736575;
  localparam logic [63:0] SipC1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SipC2 = 64'h6c7967656e657261;
  localparam logic [63:0] SipC3 = 64'h7465646279746573;
  localparam logic [63:0] FinalXor = 64'h0000_0000_0000_00ff;

  // Configuration register indexes
  localparam logic CfgKeyLow  = 1'b0;
  localparam logic CfgKeyHigh = 1'b1;

  // Round counter marks: absorb ends after round 1, finalisation after round 5
  localparam int RndW = 3;
  localparam logic [RndW-1:0] AbsorbRnd = 3'd1;
  localparam logic [RndW-1:0] FinalRnd  = 3'd5;

  // Queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [63:0] word;
    logic        first;
    logic        last;
  } q_item_t;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lanes_t;

  typedef struct packed {
    logic            busy;
    logic [RndW-1:0] rnd;
  } back_status_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int n);
    return (x << n) | (x >> (64 - n));
  endfunction

  // One ARX round over the four lanes
  function automatic lanes_t sip_round(input lanes_t v);
    logic [63:0] a0;
    logic [63:0] a1;
    logic [63:0] a2;
    logic [63:0] a3;
    lanes_t      r;
    a0 = v.v0 + v.v1;
    a2 = v.v2 + v.v3;
    a1 = rotl(v.v1, 13) ^ a0;
    a3 = rotl(v.v3, 16) ^ a2;
    a0 = rotl(a0, 32);
    a2 = a2 + a1;
    a0 = a0 + a3;
    a1 = rotl(a1, 17) ^ a2;
    a3 = rotl(a3, 21) ^ a0;
    a2 = rotl(a2, 32);
    r.v0 = a0;
    r.v1 = a1;
    r.v2 = a2;
    r.v3 = a3;
    return r;
  endfunction

  function automatic lanes_t init_lanes(input logic [63:0] k0, input logic [63:0] k1);
    lanes_t r;
    r.v0 = k0 ^ SipC0;
    r.v1 = k1 ^ SipC1;
    r.v2 = k0 ^ SipC2;
    r.v3 = k1 ^ SipC3;
    return r;
  endfunction

endpackage

// File: design/sh24_queue.sv
module sh24_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  sh24_pkg::q_item_t      push_item,
  output logic                   full,
  input  logic                   pop,
  output logic                   not_empty,
  output sh24_pkg::q_item_t      pop_item,
  output logic [sh24_pkg::QCntW-1:0] level
);
  import sh24_pkg::*;

  q_item_t            ent_r [QDepth];
  logic [QPtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCntW'(QDepth));
  assign not_empty = (cnt_r != '0);
  assign pop_item  = ent_r[rd_ptr_r];
  assign level     = cnt_r;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + QPtrW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCntW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: design/sh24_front.sv
module sh24_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       in_data_word,
  input  logic [2:0]        in_tail_bytes,
  input  logic              in_last,
  input  logic              q_full,
  output logic              q_push,
  output sh24_pkg::q_item_t q_item
);
  import sh24_pkg::*;

  logic [7:0] len_r, len_nxt;
  logic       mid_r, mid_nxt;
  logic [7:0] len_base;
  logic [7:0] total;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign len_base = mid_r ? len_r : 8'd0;
  assign total    = len_base + {5'd0, in_tail_bytes};

  // Classify the beat and build the word to absorb
  always_comb begin
    q_item.first = !mid_r;
    q_item.last  = in_last;
    q_item.word  = in_data_word;
    if (in_last) begin
      for (int i = 0; i < 7; i++) begin
        q_item.word[8*i +: 8] = (3'(i) < in_tail_bytes) ? in_data_word[8*i +: 8] : 8'd0;
      end
      q_item.word[63:56] = total;
    end
  end

  // Byte count and message position
  always_comb begin
    len_nxt = len_r;
    mid_nxt = mid_r;
    if (q_push) begin
      if (in_last) begin
        len_nxt = 8'd0;
        mid_nxt = 1'b0;
      end else begin
        len_nxt = len_base + 8'd8;
        mid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= 8'd0;
      mid_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      mid_r <= mid_nxt;
    end
  end

endmodule

// File: design/sh24_back.sv
module sh24_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic                   q_valid,
  input  sh24_pkg::q_item_t      q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [63:0]            out_hash_value,
  output sh24_pkg::back_status_t status
);
  import sh24_pkg::*;

  logic [63:0]     key_lo_r, key_hi_r;
  lanes_t          v_r, v_nxt;
  logic [63:0]     word_r, word_nxt;
  logic            last_r, last_nxt;
  logic            busy_r, busy_nxt;
  logic [RndW-1:0] rnd_r, rnd_nxt;
  logic            ov_r, ov_nxt;
  logic [63:0]     hash_r, hash_nxt;
  lanes_t          base;
  lanes_t          rin;
  lanes_t          rout;
  logic            hold;

  assign q_pop          = !busy_r && q_valid;
  assign out_valid      = ov_r;
  assign out_hash_value = hash_r;
  assign status.busy    = busy_r;
  assign status.rnd     = rnd_r;

  // Key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= 64'd0;
      key_hi_r <= 64'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgKeyLow:  key_lo_r <= cfg_data;
        CfgKeyHigh: key_hi_r <= cfg_data;
        default:    key_lo_r <= key_lo_r;
      endcase
    end
  end

  // Round input: fresh lanes at message start, word folded into v3
  always_comb begin
    base    = q_item.first ? init_lanes(key_lo_r, key_hi_r) : v_r;
    base.v3 = base.v3 ^ q_item.word;
    rin     = q_pop ? base : v_r;
    rout    = sip_round(rin);
  end

  // Final round waits while the output register is still full
  assign hold = busy_r && (rnd_r == FinalRnd) && ov_r && !out_ready;

  // Round sequencer
  always_comb begin
    v_nxt    = v_r;
    word_nxt = word_r;
    last_nxt = last_r;
    busy_nxt = busy_r;
    rnd_nxt  = rnd_r;
    hash_nxt = hash_r;
    ov_nxt   = ov_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    if (q_pop) begin
      v_nxt    = rout;
      word_nxt = q_item.word;
      last_nxt = q_item.last;
      busy_nxt = 1'b1;
      rnd_nxt  = AbsorbRnd;
    end else if (busy_r && !hold) begin
      v_nxt   = rout;
      rnd_nxt = rnd_r + RndW'(1);
      if (rnd_r == AbsorbRnd) begin
        v_nxt.v0 = rout.v0 ^ word_r;
        if (last_r) begin
          v_nxt.v2 = rout.v2 ^ FinalXor;
        end else begin
          busy_nxt = 1'b0;
        end
      end
      if (rnd_r == FinalRnd) begin
        busy_nxt = 1'b0;
        hash_nxt = rout.v0 ^ rout.v1 ^ rout.v2 ^ rout.v3;
        ov_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      rnd_r  <= rnd_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Lanes and result, no reset
  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    word_r <= word_nxt;
    last_r <= last_nxt;
    hash_r <= hash_nxt;
  end

endmodule

// File: design/siphash_2_4_engine.sv
// Each accepted beat waits in the queue until the round unit is free; the hash appears
// on out_valid once the last beat of a message has been through its rounds.
// While busy, one shared round unit does one ARX round a cycle, stalling its final
// round while the last hash waits on out_ready; a 2-entry queue decouples the ports.
// Reset (rst_n low, synchronous) clears keys, byte count, queue and result valid;
// the next beat starts a fresh message.
module siphash_2_4_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [2:0]  in_tail_bytes,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash_value
);
  import sh24_pkg::*;

  q_item_t          push_item;
  q_item_t          pop_item;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_valid;
  logic [QCntW-1:0] q_level;
  back_status_t     status;

  // Front: accepts beats, masks the tail and counts bytes
  sh24_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_word  (in_data_word),
    .in_tail_bytes (in_tail_bytes),
    .in_last       (in_last),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  sh24_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (pop_item),
    .level     (q_level)
  );

  // Back: round unit, keys and result register
  sh24_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_valid        (q_valid),
    .q_item         (pop_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value),
    .status         (status)
  );

  // Checks
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    status.busy |-> (status.rnd >= AbsorbRnd && status.rnd <= FinalRnd))
    else $error("round counter out of range");

  a_q_level: assert property (@(posedge clk) disable iff (!rst_n)
    (q_level <= QCntW'(QDepth)) && (in_ready == (q_level != QCntW'(QDepth))))
    else $error("queue level and in_ready disagree");

  a_hash_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(status.busy && status.rnd == FinalRnd))
    else $error("result raised outside the final round");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

// File: dv/siphash_2_4_checker.sv
module siphash_2_4_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [2:0]  in_tail_bytes,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_hash_value,
  output int unsigned fail_count,
  output int unsigned hashes_due,
  output int unsigned hashes_seen
);
  import sh24_pkg::*;

  typedef struct packed {
    logic [63:0] s0;
    logic [63:0] s1;
    logic [63:0] s2;
    logic [63:0] s3;
  } sip_lanes_t;

  // Shadow of the key registers and the running hash state
  logic [63:0] key_lo;
  logic [63:0] key_hi;
  sip_lanes_t  lanes;
  logic [7:0]  byte_total;
  logic        in_msg;
  logic [63:0] hash_q[$];

  function automatic logic [63:0] rol64(input logic [63:0] x, input int unsigned n);
    return (x << n) | (x >> (64 - n));
  endfunction

  // n ARX rounds over the four lanes
  function automatic sip_lanes_t arx_rounds(input sip_lanes_t st, input int unsigned n);
    sip_lanes_t t;
    t = st;
    for (int unsigned r = 0; r < n; r++) begin
      t.s0 = t.s0 + t.s1;
      t.s2 = t.s2 + t.s3;
      t.s1 = rol64(t.s1, 13) ^ t.s0;
      t.s3 = rol64(t.s3, 16) ^ t.s2;
      t.s0 = rol64(t.s0, 32);
      t.s2 = t.s2 + t.s1;
      t.s0 = t.s0 + t.s3;
      t.s1 = rol64(t.s1, 17) ^ t.s2;
      t.s3 = rol64(t.s3, 21) ^ t.s0;
      t.s2 = rol64(t.s2, 32);
    end
    return t;
  endfunction

  function automatic sip_lanes_t absorb_word(input sip_lanes_t st, input logic [63:0] w);
    sip_lanes_t t;
    t = st;
    t.s3 = t.s3 ^ w;
    t = arx_rounds(t, 2);
    t.s0 = t.s0 ^ w;
    return t;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t checker: %s", $time, what);
    fail_count++;
  endtask

  // Fold one accepted beat into the shadow state; a last beat yields a hash
  task automatic take_beat(input logic [63:0] word, input logic [2:0] tail,
                           input logic last);
    logic [63:0] mask;
    logic [63:0] final_word;
    logic [7:0]  total;
    if (!in_msg) begin
      lanes.s0   = key_lo ^ SipC0;
      lanes.s1   = key_hi ^ SipC1;
      lanes.s2   = key_lo ^ SipC2;
      lanes.s3   = key_hi ^ SipC3;
      byte_total = 8'd0;
    end
    if (!last) begin
      // tail count is ignored on a middle beat
      lanes      = absorb_word(lanes, word);
      byte_total = byte_total + 8'd8;
      in_msg     = 1'b1;
    end else begin
      total      = byte_total + {5'd0, tail};
      mask       = (tail == 3'd0) ? 64'd0 : ((64'd1 << (8 * tail)) - 64'd1);
      final_word = (word & mask) | {total, 56'd0};
      lanes      = absorb_word(lanes, final_word);
      lanes.s2   = lanes.s2 ^ FinalXor;
      lanes      = arx_rounds(lanes, 4);
      hash_q.push_back(lanes.s0 ^ lanes.s1 ^ lanes.s2 ^ lanes.s3);
      byte_total = 8'd0;
      in_msg     = 1'b0;
    end
  endtask

  always @(posedge clk) begin : watch
    logic [63:0] want;
    if (!rst_n) begin
      key_lo      = 64'd0;
      key_hi      = 64'd0;
      byte_total  = 8'd0;
      in_msg      = 1'b0;
      fail_count  = 0;
      hashes_seen = 0;
      hash_q.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_valid && out_ready) begin
        if (hash_q.size() == 0) begin
          report_mismatch($sformatf("hash %h with none pending", out_hash_value));
        end else begin
          want = hash_q.pop_front();
          hashes_seen++;
          if (out_hash_value !== want)
            report_mismatch($sformatf("hash got %h, expected %h", out_hash_value, want));
        end
      end
      if (in_valid && in_ready)
        take_beat(in_data_word, in_tail_bytes, in_last);
      if (cfg_we) begin
        if (cfg_index == CfgKeyLow)
          key_lo = cfg_data;
        else
          key_hi = cfg_data;
      end
    end
    hashes_due = hash_q.size();
  end

endmodule

// File: dv/tb.sv
module tb;
  import sh24_pkg::*;

  typedef enum logic [1:0] {RxFree, RxCoin, RxStingy, RxPulse} rx_mode_t;

  localparam int NumKeySets   = 6;
  localparam int BeatsPerSet  = 200;
  localparam int DrainCycles  = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CfgKeyLow;
  logic [63:0] cfg_data = 64'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_data_word = 64'd0;
  logic [2:0]  in_tail_bytes = 3'd0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_hash_value;

  int unsigned fail_count;
  int unsigned hashes_due;
  int unsigned hashes_seen;

  int unsigned beats_sent = 0;
  int unsigned msgs_sent  = 0;
  int unsigned burst_left = 0;
  logic        flat_out   = 1'b0;
  rx_mode_t    rx_mode    = RxFree;

  always #6 clk = ~clk;

  siphash_2_4_engine dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_word   (in_data_word),
    .in_tail_bytes  (in_tail_bytes),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

  siphash_2_4_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_word   (in_data_word),
    .in_tail_bytes  (in_tail_bytes),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value),
    .fail_count     (fail_count),
    .hashes_due     (hashes_due),
    .hashes_seen    (hashes_seen)
  );

  // Offer one beat, entering and leaving at a falling edge
  task automatic send_beat(input logic [63:0] word, input logic [2:0] tail,
                           input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
      gap = flat_out ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_data_word  <= word;
    in_tail_bytes <= tail;
    in_last       <= last;
    burst_left--;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Random message: mostly short, some medium, a few past the length wrap
  task automatic send_message();
    int unsigned words;
    int unsigned pick;
    pick     = $urandom_range(0, 9);
    words    = (pick < 6) ? $urandom_range(0, 3) :
               (pick < 9) ? $urandom_range(4, 12) : $urandom_range(28, 40);
    flat_out = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < words; i++)
      send_beat(rand_word(), 3'($urandom_range(0, 7)), 1'b0);
    send_beat(rand_word(), 3'($urandom_range(0, 7)), 1'b1);
    msgs_sent++;
  endtask

  // Let the block go quiet before touching the key
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (hashes_due != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_keys(input logic [63:0] lo, input logic [63:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CfgKeyLow;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_index <= CfgKeyHigh;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver back-pressure, changing character every so often
  initial begin : rx_pattern
    int unsigned hold;
    int unsigned tick;
    tick = 0;
    forever begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      hold    = $urandom_range(20, 200);
      repeat (hold) begin
        @(negedge clk);
        tick++;
        case (rx_mode)
          RxFree:   out_ready <= 1'b1;
          RxCoin:   out_ready <= 1'($urandom_range(0, 1));
          RxStingy: out_ready <= ($urandom_range(0, 7) == 0);
          default:  out_ready <= ((tick % 6) < 3);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [63:0] lo;
    logic [63:0] hi;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed messages under the reset key of all zeros
    send_beat('1, 3'd0, 1'b1);                  // empty message, dirty word
    msgs_sent++;
    send_beat('1, 3'd7, 1'b1);
    msgs_sent++;
    send_beat('0, 3'd7, 1'b1);
    msgs_sent++;
    for (int t = 1; t < 7; t++) begin
      send_beat('1, 3'(t), 1'b1);
      msgs_sent++;
    end
    send_beat('1, 3'd7, 1'b0);                  // tail count ignored mid message
    send_beat('0, 3'd5, 1'b0);
    send_beat(rand_word(), 3'd3, 1'b1);
    msgs_sent++;
    send_beat(64'h0706050403020100, 3'd0, 1'b0);
    send_beat(rand_word(), 3'd0, 1'b1);
    msgs_sent++;
    send_beat(rand_word(), 3'd2, 1'b0);
    send_beat(rand_word(), 3'd6, 1'b0);
    send_beat('1, 3'd7, 1'b1);
    msgs_sent++;
    send_beat(64'h8000000000000000, 3'd1, 1'b0);
    send_beat(64'h0000000000000001, 3'd4, 1'b0);
    send_beat(64'h8000000000000001, 3'd4, 1'b1);
    msgs_sent++;

    // Random traffic under a series of keys, extremes first
    for (int k = 0; k < NumKeySets; k++) begin
      settle();
      case (k)
        0:       begin lo = '1; hi = '1; end
        1:       begin lo = '0; hi = '1; end
        2:       begin lo = '1; hi = '0; end
        3:       begin lo = 64'h0706050403020100; hi = 64'h0f0e0d0c0b0a0908; end
        default: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
      endcase
      set_keys(lo, hi);
      begin : one_key
        int unsigned start;
        start = beats_sent;
        while (beats_sent - start < BeatsPerSet) send_message();
      end
    end

    // Drain and verdict
    in_valid <= 1'b0;
    while (hashes_due != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d beats in %0d messages over %0d key settings;", beats_sent,
             msgs_sent, NumKeySets + 1);
    $display("%0d hashes compared, %0d mismatches", hashes_seen, fail_count);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog
  initial begin
    #(12 * 400_000);
    $display("watchdog expired with %0d hashes outstanding", hashes_due);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
